// File: hdl/lznt1_pkg.sv
// Shared types and constants of the LZNT1 stream decompressor.
`timescale 1ns / 1ps
package lznt1_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned PROD_W = 13;
    localparam int unsigned ADDR_W = 12;
    localparam int unsigned HIST_SIZE = 4096;

    localparam logic [15:0] HDR_COMPRESSED = 16'h8000;
    localparam logic [15:0] HDR_SIG_MASK   = 16'h7000;
    localparam logic [15:0] HDR_SIG        = 16'h3000;
    localparam logic [15:0] HDR_SIZE_MASK  = 16'h0FFF;

    localparam logic CFG_SOURCE_LENGTH   = 1'b0;
    localparam logic CFG_OUTPUT_CAPACITY = 1'b1;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_BUSY        = 4'd1,
        ST_AFTER_END   = 4'd2,
        ST_BAD_SIG     = 4'd3,
        ST_CHUNK_INPUT = 4'd4,
        ST_RAW_OUTPUT  = 4'd5,
        ST_CHUNK_SIZE  = 4'd6,
        ST_LIT_OUTPUT  = 4'd7,
        ST_TRUNC_WORD  = 4'd8,
        ST_BREF_BEFORE = 4'd9,
        ST_BREF_OUTPUT = 4'd10
    } t_status;

    typedef enum logic [5:0] {
        PH_HDR_LO  = 6'b000001,
        PH_HDR_HI  = 6'b000010,
        PH_RAW     = 6'b000100,
        PH_FLAG    = 6'b001000,
        PH_ELEM    = 6'b010000,
        PH_WORD_HI = 6'b100000
    } t_phase;

    // Displacement bit count for a back-reference word.
    function automatic logic [4:0] disp_bits(input logic [PROD_W-1:0] produced);
        logic [4:0] res;
        logic       hit;
        res = 5'd4;
        hit = 1'b0;
        for (int m = 12; m > 4; m--) begin
            if (!hit && ((PROD_W'(1) << (m - 1)) < produced)) begin
                res = 5'(m);
                hit = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// File: hdl/lznt1_stream_decompressor.sv
// Top level of the LZNT1 stream decompressor.
//
//  channel   | direction | tdata (low bit up)                          | tuser
//  s_axis    | in        | in_byte[7:0]                                | func
//  m_axis    | out       | out_byte, status, copy_pending, finished,   | out_valid
//            |           | total_out, 2 zero pad bits (48 bits)        |
//  cfg       | in        | 0 source_length, 1 output_capacity          | -
//
// One transaction in per cycle unless stalled, one result transaction out for each.
// A result passes the history RAM read stage and then the output register.
// Scalar state updates at acceptance; a copy byte is written back to history when its
// result leaves the read stage, and a read of that entry in the same cycle is forwarded.
// Reset (synchronous) and any config write start a new job; history is not cleared.
// The input stalls only while the read stage holds a result the output cannot take.
`timescale 1ns / 1ps
module lznt1_stream_decompressor #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // in_byte[7:0]
    input  logic        i_s_axis_tuser,   // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // out_byte, status, copy_pending, finished, total_out
    output logic        o_m_axis_tuser,   // out_valid
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import lznt1_pkg::*;

    localparam int unsigned EW = ((COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W) + 1;

    // job state
    logic [POS_W-1:0]       r_src, r_cap;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [POS_W-1:0]       r_end, n_end;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [PROD_W-1:0]      r_prod, n_prod;
    t_phase                 r_phase, n_phase;
    logic [7:0]             r_flags, n_flags;
    logic [3:0]             r_fidx, n_fidx;
    logic [7:0]             r_hold, n_hold;
    logic [PROD_W-1:0]      r_rem, n_rem;
    logic [PROD_W-1:0]      r_dist, n_dist;
    logic [3:0]             r_err, n_err;
    logic                   r_done, n_done;

    // read stage
    logic              r_s1_v, r_s1_ovalid, r_s1_copy, r_s1_we, r_s1_fwd;
    logic [7:0]        r_s1_lit, r_fwd_data;
    logic [ADDR_W-1:0] r_s1_waddr;
    logic [3:0]        r_s1_status;
    logic              r_s1_pend, r_s1_fin;
    logic [31:0]       r_s1_total;

    // output register
    logic        r_o_v, r_o_user;
    logic [47:0] r_o_data;

    // per-item decode
    logic              accept, o_adv, s1_move, s1_free;
    logic              st_ovalid, st_copy, st_we;
    logic [7:0]        st_lit;
    logic [3:0]        st_status;
    logic [ADDR_W-1:0] rd_addr, st_waddr;
    logic [7:0]        ram_q, s1_byte;
    logic [15:0]       word;
    logic [4:0]        dbits, lbits;
    logic [PROD_W-1:0] blen, bdisp;
    logic [13:0]       pay;

    assign o_adv   = !r_o_v || i_m_axis_tready;
    assign s1_move = r_s1_v && o_adv;
    assign s1_free = !r_s1_v || o_adv;
    assign o_s_axis_tready = s1_free;
    assign accept  = i_s_axis_tvalid && s1_free;

    assign s1_byte = r_s1_copy ? (r_s1_fwd ? r_fwd_data : ram_q) : r_s1_lit;

    assign word  = {i_s_axis_tdata, r_hold};
    assign dbits = disp_bits(r_prod);
    assign lbits = 5'd16 - dbits;
    assign blen  = PROD_W'((word & ((16'd1 << lbits) - 16'd1)) + 16'd3);
    assign bdisp = PROD_W'((word >> lbits) + 16'd1);
    assign pay   = 14'({1'b0, word[11:0]}) + 14'd1;
    assign rd_addr = ADDR_W'(r_prod - r_dist);

    lznt1_ram #(.WIDTH(8), .DEPTH(HIST_SIZE)) u_hist (
        .i_clk   (i_clk),
        .i_we    (s1_move && r_s1_we),
        .i_waddr (r_s1_waddr),
        .i_wdata (s1_byte),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Step one item against the current job state.
    always_comb begin
        logic [POS_W-1:0] pos1;
        logic             to_hdr;
        pos1    = r_pos + 32'd1;
        to_hdr  = 1'b0;
        n_pos   = r_pos;
        n_end   = r_end;
        n_count = r_count;
        n_prod  = r_prod;
        n_phase = r_phase;
        n_flags = r_flags;
        n_fidx  = r_fidx;
        n_hold  = r_hold;
        n_rem   = r_rem;
        n_dist  = r_dist;
        n_err   = r_err;
        n_done  = r_done;
        st_ovalid = 1'b0;
        st_copy   = 1'b0;
        st_we     = 1'b0;
        st_lit    = 8'd0;
        st_status = ST_OK;
        st_waddr  = r_prod[ADDR_W-1:0];

        if (r_err != ST_OK) begin
            st_status = r_err;
        end else if (i_s_axis_tuser == FUNC_TICK) begin
            if (r_rem != '0) begin
                st_ovalid = 1'b1;
                st_copy   = 1'b1;
                st_we     = 1'b1;
                n_prod    = r_prod + PROD_W'(1);
                n_count   = r_count + COUNT_WIDTH'(1);
                n_rem     = r_rem - PROD_W'(1);
            end
        end else if (r_rem != '0) begin
            st_status = ST_BUSY;
        end else if (r_done) begin
            st_status = ST_AFTER_END;
        end else begin
            case (r_phase)
                PH_HDR_LO: begin
                    n_hold  = i_s_axis_tdata;
                    n_pos   = pos1;
                    n_phase = PH_HDR_HI;
                end
                PH_HDR_HI: begin
                    n_pos = pos1;
                    if (word == 16'd0) begin
                        n_done = 1'b1;
                    end else if ((word & HDR_SIG_MASK) != HDR_SIG) begin
                        n_err = ST_BAD_SIG;
                    end else if ({2'b0, pos1} + 34'(pay) > {2'b0, r_src}) begin
                        n_err = ST_CHUNK_INPUT;
                    end else begin
                        n_end  = pos1 + 32'(pay);
                        n_prod = '0;
                        if ((word & HDR_COMPRESSED) == 16'd0) begin
                            if (EW'(r_count) + EW'(pay) > EW'(r_cap)) begin
                                n_err = ST_RAW_OUTPUT;
                            end else begin
                                n_phase = PH_RAW;
                            end
                        end else begin
                            n_phase = PH_FLAG;
                        end
                    end
                end
                PH_RAW: begin
                    st_ovalid = 1'b1;
                    st_lit    = i_s_axis_tdata;
                    n_pos     = pos1;
                    n_count   = r_count + COUNT_WIDTH'(1);
                    to_hdr    = (pos1 >= r_end);
                end
                PH_FLAG: begin
                    n_flags = i_s_axis_tdata;
                    n_fidx  = 4'd0;
                    n_pos   = pos1;
                    if (pos1 >= r_end) begin
                        to_hdr = 1'b1;
                    end else begin
                        n_phase = PH_ELEM;
                    end
                end
                PH_ELEM: begin
                    if (r_prod >= PROD_W'(HIST_SIZE)) begin
                        n_err = ST_CHUNK_SIZE;
                    end else if (!r_flags[r_fidx[2:0]]) begin
                        if (EW'(r_count) >= EW'(r_cap)) begin
                            n_err = ST_LIT_OUTPUT;
                        end else begin
                            st_ovalid = 1'b1;
                            st_we     = 1'b1;
                            st_lit    = i_s_axis_tdata;
                            n_prod    = r_prod + PROD_W'(1);
                            n_count   = r_count + COUNT_WIDTH'(1);
                            n_pos     = pos1;
                            n_fidx    = r_fidx + 4'd1;
                            if (pos1 >= r_end) begin
                                to_hdr = 1'b1;
                            end else if (r_fidx + 4'd1 >= 4'd8) begin
                                n_phase = PH_FLAG;
                            end else begin
                                n_phase = PH_ELEM;
                            end
                        end
                    end else if ({1'b0, r_pos} + 33'd2 > {1'b0, r_end}) begin
                        n_err = ST_TRUNC_WORD;
                    end else begin
                        n_hold  = i_s_axis_tdata;
                        n_pos   = pos1;
                        n_fidx  = r_fidx + 4'd1;
                        n_phase = PH_WORD_HI;
                    end
                end
                PH_WORD_HI: begin
                    n_pos = pos1;
                    if (bdisp > r_prod) begin
                        n_err = ST_BREF_BEFORE;
                    end else if (14'(blen) + 14'(r_prod) > 14'(HIST_SIZE)) begin
                        n_err = ST_CHUNK_SIZE;
                    end else if (EW'(r_count) + EW'(blen) > EW'(r_cap)) begin
                        n_err = ST_BREF_OUTPUT;
                    end else begin
                        n_rem  = blen;
                        n_dist = bdisp;
                        if (pos1 >= r_end) begin
                            to_hdr = 1'b1;
                        end else if (r_fidx >= 4'd8) begin
                            n_phase = PH_FLAG;
                        end else begin
                            n_phase = PH_ELEM;
                        end
                    end
                end
                default: begin
                    to_hdr = 1'b1;
                end
            endcase
            // Header expected: finish when fewer than two source bytes remain.
            if (to_hdr) begin
                n_phase = PH_HDR_LO;
                if ({1'b0, n_pos} + 33'd2 > {1'b0, r_src}) begin
                    n_done = 1'b1;
                end
            end
            if (n_err != ST_OK) begin
                st_status = n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src   <= '0;
            r_cap   <= '0;
            r_pos   <= '0;
            r_end   <= '0;
            r_count <= '0;
            r_prod  <= '0;
            r_phase <= PH_HDR_LO;
            r_flags <= '0;
            r_fidx  <= 4'd8;
            r_hold  <= '0;
            r_rem   <= '0;
            r_dist  <= '0;
            r_err   <= ST_OK;
            r_done  <= 1'b1;
        end else if (i_cfg_we) begin
            // Start a new job with the written register.
            if (i_cfg_index == CFG_SOURCE_LENGTH) begin
                r_src  <= i_cfg_data;
                r_done <= (i_cfg_data < 32'd2);
            end else begin
                r_cap  <= i_cfg_data;
                r_done <= (r_src < 32'd2);
            end
            r_pos   <= '0;
            r_end   <= '0;
            r_count <= '0;
            r_prod  <= '0;
            r_phase <= PH_HDR_LO;
            r_flags <= '0;
            r_fidx  <= 4'd8;
            r_hold  <= '0;
            r_rem   <= '0;
            r_dist  <= '0;
            r_err   <= ST_OK;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_end   <= n_end;
            r_count <= n_count;
            r_prod  <= n_prod;
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_fidx  <= n_fidx;
            r_hold  <= n_hold;
            r_rem   <= n_rem;
            r_dist  <= n_dist;
            r_err   <= n_err;
            r_done  <= n_done;
        end
    end

    // Read stage and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= accept;
            end
            if (o_adv) begin
                r_o_v <= r_s1_v;
            end
        end
        if (accept) begin
            r_s1_ovalid <= st_ovalid;
            r_s1_copy   <= st_copy;
            r_s1_we     <= st_we;
            r_s1_lit    <= st_lit;
            r_s1_waddr  <= st_waddr;
            r_s1_status <= st_status;
            r_s1_pend   <= (n_rem != '0);
            r_s1_fin    <= n_done;
            r_s1_total  <= 32'(n_count);
            // Catch the write that lands in the same cycle as this read.
            r_s1_fwd    <= s1_move && r_s1_we && (r_s1_waddr == rd_addr);
            r_fwd_data  <= s1_byte;
        end
        if (s1_move) begin
            r_o_user <= r_s1_ovalid;
            r_o_data <= {2'b00, r_s1_total, r_s1_fin, r_s1_pend, r_s1_status, s1_byte};
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_user;
endmodule

// File: hdl/lznt1_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lznt1_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

// File: hdl/lznt1_checker.sv
// Port-level checks of the LZNT1 stream decompressor, bound to the top level.
`timescale 1ns / 1ps
module lznt1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);
    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // A produced byte never carries a status.
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[11:8] == 4'd0)
        else $error("byte emitted with nonzero status");

    // Drop the byte when nothing is produced.
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("byte nonzero without out_valid");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result after reset");
endmodule

bind lznt1_stream_decompressor lznt1_checker u_lznt1_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
